>>> rtl/core/deql_pkg.sv
// Shared types and constants for the double-ended queue with listing.
// Used by the cell, the cell chain and the top level; no dependencies.
`timescale 1ns / 1ps

package deql_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned VALUE_W  = 30;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned STATUS_W = 2;

  // Largest value the queue stores; larger pushes saturate to it.
  localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd999999999;

  // Operation codes carried by an input item.
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_LIST       = 3'd4;

  // Status codes reported with every result item.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // Input item.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  entry_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [VALUE_W-1:0]  listed_value;
    logic                queue_empty;
    logic [STATUS_W-1:0] op_status;
    logic                last_of_listing;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_RIGHT,
    CMD_SHIFT_LEFT,
    CMD_LOAD_BACK,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

>>> rtl/core/double_ended_queue_with_listing.sv
// Double-ended queue that lists its whole contents after every operation.
// The input item is taken in S_IDLE; S_LIST then loads each result item into the output register.
// No new input item is taken until the listing for the last one is finished;
// the listing rotates the cell chain once per result item, one item per cycle unless out_ready stalls it.
// Reset (rst_n, synchronous, active low) empties the queue; cell contents are not cleared.
// Depends on deql_pkg and deql_chain.
`timescale 1ns / 1ps

module double_ended_queue_with_listing
  import deql_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t              state_r;
  state_t              state_nxt;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [CW-1:0]       remaining_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                empty_list_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                in_accept;
  logic                list_load;
  logic                list_last;
  logic [VALUE_W-1:0]  value_sat;
  logic [VALUE_W-1:0]  head_value;
  cell_ctrl_t          cell_ctrl;

  assign in_accept = in_valid && in_ready;
  assign value_sat = (in_item.entry_value > VALUE_MAX) ? VALUE_MAX : in_item.entry_value;
  assign list_last = empty_list_r || (remaining_r == CW'(1));

  // Operation decode and listing rotation drive the cell chain.
  always_comb begin
    cell_ctrl.cmd   = CMD_HOLD;
    cell_ctrl.value = value_sat;
    count_nxt       = count_r;
    status_nxt      = status_r;
    if (in_accept) begin
      status_nxt = ST_OK;
      unique case (in_item.opcode) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count_r == CW'(QUEUE_DEPTH)) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            cell_ctrl.cmd = (in_item.opcode == OP_PUSH_FRONT) ? CMD_SHIFT_RIGHT
                                                              : CMD_LOAD_BACK;
            count_nxt     = count_r + CW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            cell_ctrl.cmd = (in_item.opcode == OP_POP_FRONT) ? CMD_SHIFT_LEFT : CMD_HOLD;
            count_nxt     = count_r - CW'(1);
          end
        end
        default: begin
          // List only, and the unused codes, leave the queue alone.
          status_nxt = ST_OK;
        end
      endcase
    end else if (list_load && !empty_list_r) begin
      cell_ctrl.cmd = CMD_ROTATE;
    end
  end

  deql_chain #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_chain (
    .clk     (clk),
    .ctrl_i  (cell_ctrl),
    .count_i (count_r),
    .head_o  (head_value)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_LIST;
      S_LIST: if (list_load && list_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    list_load = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_LIST: list_load = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      remaining_r  <= '0;
      status_r     <= ST_OK;
      empty_list_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (in_accept) begin
        remaining_r  <= count_nxt;
        empty_list_r <= (count_nxt == '0);
      end else if (list_load) begin
        remaining_r <= remaining_r - CW'(1);
      end
      if (list_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register: one result item per load.
  always_ff @(posedge clk) begin
    if (list_load) begin
      out_item_r.listed_value    <= empty_list_r ? '0 : head_value;
      out_item_r.queue_empty     <= empty_list_r;
      out_item_r.op_status       <= status_r;
      out_item_r.last_of_listing <= list_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  // An accepted item always starts a listing.
  a_accept_lists: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_LIST && !in_ready))
    else $error("accepted item did not start a listing");

  // The entry count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // An empty result item is always the final one of its listing.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.queue_empty) |-> out_item.last_of_listing)
    else $error("empty result item not marked last");

  // Loading the final result item frees the input side at once.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (list_load && list_last) |=> (in_ready && out_valid && out_item.last_of_listing))
    else $error("input not freed after final result item");
`endif

endmodule

>>> rtl/core/deql_cell.sv
// One storage cell of the queue chain: holds a single entry.
// Depends on deql_pkg for the command struct and widths.
`timescale 1ns / 1ps

module deql_cell
  import deql_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl_i,
  input  logic [CW-1:0]      count_i,
  input  logic [VALUE_W-1:0] left_i,
  input  logic [VALUE_W-1:0] right_i,
  input  logic [VALUE_W-1:0] head_i,
  output logic [VALUE_W-1:0] data_o
);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  // Choose the new content from the neighbours, the head or the pushed value.
  always_comb begin
    data_nxt = data_r;
    case (ctrl_i.cmd)
      CMD_SHIFT_RIGHT: data_nxt = left_i;
      CMD_SHIFT_LEFT:  data_nxt = right_i;
      CMD_LOAD_BACK: begin
        if (count_i == CW'(IDX)) data_nxt = ctrl_i.value;
      end
      CMD_ROTATE: begin
        // The last occupied cell takes the head, so the listing wraps round.
        data_nxt = (count_i == CW'(IDX + 1)) ? head_i : right_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Entry storage; contents are meaningless until written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

>>> rtl/core/deql_chain.sv
// Row of queue cells, front entry in cell 0, joined to their neighbours.
// Depends on deql_pkg and deql_cell.
`timescale 1ns / 1ps

module deql_chain
  import deql_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int CW    = 6
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl_i,
  input  logic [CW-1:0]      count_i,
  output logic [VALUE_W-1:0] head_o
);

  logic [VALUE_W-1:0] cell_data [DEPTH];

  // Cell 0 takes the pushed value on a shift right; the last cell reads
  // itself on the right, which only matters for entries no longer held.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deql_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .left_i  ((i == 0) ? ctrl_i.value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_i (cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule
